FILE: rtl/fbf_pkg.sv
// Shared constants, payload types and command codes of the free-block pool.
`default_nettype none

package fbf_pkg;

   // Pool geometry and field widths
   localparam int POOL_DEPTH = 1024;
   localparam int IDX_BITS   = $clog2(POOL_DEPTH);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int BLOCK_BITS = 16;
   localparam int ERASE_BITS = 24;
   localparam int CAP_BITS   = 11;
   localparam int CMD_BITS   = 2;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIND = 2'd2;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   // One ring slot: block number and its erase count at push time
   typedef struct packed {
      logic [BLOCK_BITS-1:0] block;
      logic [ERASE_BITS-1:0] erase;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic [BLOCK_BITS-1:0] block_number;
      logic [ERASE_BITS-1:0] block_erase_count;
   } req_payload_type;

   typedef struct packed {
      logic                  ok;
      logic [BLOCK_BITS-1:0] result_block;
      cnt_type               occupancy;
   } rsp_payload_type;

   // Slot memory access from the controller
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      slot_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

FILE: rtl/fbf_ifs.sv
// Valid/ready channel interfaces for commands, results and the capacity register.
`default_nettype none

interface fbf_req_if;
   import fbf_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fbf_rsp_if;
   import fbf_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fbf_csr_if;
   import fbf_pkg::*;
   logic                valid;
   logic                ready;
   logic [CAP_BITS-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/fbf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module fbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/fbf_core.sv
// Ring pointer control, pop read-out and least-erased scan over the slot memory.
`default_nettype none

module fbf_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fbf_pkg::cnt_type  capacity,
   fbf_req_if.sink                req_ch,
   fbf_rsp_if.source              rsp_ch,
   output fbf_pkg::ram_req_type   ram_req,
   input  wire fbf_pkg::slot_type rd_data
);
   import fbf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   idx_type         head_ff, head_in;
   idx_type         tail_ff, tail_in;
   cnt_type         count_ff, count_in;
   idx_type         scan_addr_ff, scan_addr_in;
   cnt_type         issue_left_ff, issue_left_in;
   cnt_type         recv_left_ff, recv_left_in;
   logic            rd_pending_ff;
   logic            first_ff, first_in;
   slot_type        best_ff, best_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            accept;
   logic            take;
   slot_type        cand;

   // Step a ring index, wrapping at the capacity in use
   function automatic idx_type adv_idx(input idx_type idx, input cnt_type cap);
      cnt_type nxt;
      nxt = cnt_type'(idx) + cnt_type'(1);
      return (nxt >= cap) ? '0 : nxt[IDX_BITS-1:0];
   endfunction

   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Keep the first slot of a scan, then only a strictly smaller erase count
   assign take = first_ff || (rd_data.erase < best_ff.erase);
   assign cand = take ? rd_data : best_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      issue_left_in = issue_left_ff;
      recv_left_in  = recv_left_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      ram_req       = '0;
      ram_req.rd_addr = scan_addr_ff;
      ram_req.wr_addr = tail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Default answer: failure with unchanged occupancy
               rsp_data_in.ok           = 1'b0;
               rsp_data_in.result_block = '0;
               rsp_data_in.occupancy    = count_ff;
               unique case (req_ch.data.command)
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < capacity) begin
                        ram_req.wr_en         = 1'b1;
                        ram_req.wr_data.block = req_ch.data.block_number;
                        ram_req.wr_data.erase = req_ch.data.block_erase_count;
                        tail_in               = adv_idx(tail_ff, capacity);
                        count_in              = count_ff + cnt_type'(1);
                        rsp_data_in.ok        = 1'b1;
                        rsp_data_in.occupancy = count_ff + cnt_type'(1);
                     end
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        // A pop is a one-slot scan of the head
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = head_ff;
                        head_in         = adv_idx(head_ff, capacity);
                        count_in        = count_ff - cnt_type'(1);
                        issue_left_in   = '0;
                        recv_left_in    = cnt_type'(1);
                        first_in        = 1'b1;
                        state_in        = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff != '0) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = head_ff;
                        scan_addr_in    = adv_idx(head_ff, capacity);
                        issue_left_in   = count_ff - cnt_type'(1);
                        recv_left_in    = count_ff;
                        first_in        = 1'b1;
                        state_in        = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Issue the next slot read
            if (issue_left_ff != '0) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = scan_addr_ff;
               scan_addr_in    = adv_idx(scan_addr_ff, capacity);
               issue_left_in   = issue_left_ff - cnt_type'(1);
            end
            // Fold in returning slot data; finish on the last one
            if (rd_pending_ff) begin
               best_in      = cand;
               first_in     = 1'b0;
               recv_left_in = recv_left_ff - cnt_type'(1);
               if (recv_left_ff == cnt_type'(1)) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.ok           = 1'b1;
                  rsp_data_in.result_block = cand.block;
                  rsp_data_in.occupancy    = count_ff;
                  state_in                 = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         issue_left_ff <= '0;
         recv_left_ff  <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         issue_left_ff <= issue_left_in;
         recv_left_ff  <= recv_left_in;
         rd_pending_ff <= ram_req.rd_en;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      first_ff     <= first_in;
      best_ff      <= best_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/free_block_fifo_min_wear.sv
// Push answers in the cycle after acceptance; a pop reads the head slot, then registers
// its result; find-min with n blocks held issues one slot memory read per cycle, folding
// in each registered read. Throughput: one push per cycle while results are taken. A new
// command is taken once the previous result is registered and being taken or gone.
// Synchronous reset empties the pool and sets capacity to the full depth; slot
// contents are not cleared.
`default_nettype none

module free_block_fifo_min_wear (
   input wire logic  clock,
   input wire logic  reset,
   fbf_req_if.sink   req_ch,
   fbf_rsp_if.source rsp_ch,
   fbf_csr_if.sink   csr_ch
);
   import fbf_pkg::*;

   logic [CAP_BITS-1:0]  cap_ff;
   cnt_type              capacity;
   ram_req_type          ram_req;
   logic [SLOT_BITS-1:0] ram_rd_data;

   // Capacity register, always writable
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_BITS'(POOL_DEPTH);
      end else if (csr_ch.valid) begin
         cap_ff <= csr_ch.data;
      end
   end

   // Clamp capacity into 1..POOL_DEPTH
   always_comb begin
      priority if (cap_ff == '0) begin
         capacity = cnt_type'(1);
      end else if (int'(cap_ff) > POOL_DEPTH) begin
         capacity = cnt_type'(POOL_DEPTH);
      end else begin
         capacity = cnt_type'(cap_ff);
      end
   end

   fbf_core u_core (
      .clock    (clock),
      .reset    (reset),
      .capacity (capacity),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .ram_req  (ram_req),
      .rd_data  (ram_rd_data)
   );

   fbf_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (POOL_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef SYNTHESIS
   // Never take a command while an untaken result blocks the output register
   a_no_accept_over_result: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("command accepted while result register full");

   // A push answers in the next cycle
   a_push_next_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.data.command == CMD_PUSH) |=> rsp_ch.valid)
      else $error("push result late");

   // Failed results carry no block
   a_fail_zero_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.data.ok) |-> (rsp_ch.data.result_block == '0))
      else $error("failed result carries a block");

   // Occupancy never exceeds the pool depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (int'(rsp_ch.data.occupancy) <= POOL_DEPTH))
      else $error("occupancy beyond pool depth");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/fbf_tb_pkg.sv
// Answer predictor and checker for the free-block pool testbench.
package fbf_tb_pkg;
   import fbf_pkg::*;

   // Command code that the block does not use
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   // Mismatches reported in full before only counting
   localparam int unsigned REPORT_LIMIT = 10;

   class pool_tracker;
      logic [BLOCK_BITS-1:0] slot_block [POOL_DEPTH];
      logic [ERASE_BITS-1:0] slot_erase [POOL_DEPTH];
      int unsigned head_idx;
      int unsigned tail_idx;
      int unsigned held;
      int unsigned capacity_reg;
      rsp_payload_type expected_answers [$];
      int unsigned mismatches;
      int unsigned answers_checked;
      int unsigned refused;
      int unsigned peak_held;
      int unsigned by_command [4];

      function new();
         head_idx = 0;
         tail_idx = 0;
         held = 0;
         capacity_reg = POOL_DEPTH;
         mismatches = 0;
         answers_checked = 0;
         refused = 0;
         peak_held = 0;
         foreach (by_command[i]) begin
            by_command[i] = 0;
         end
         foreach (slot_block[i]) begin
            slot_block[i] = '0;
            slot_erase[i] = '0;
         end
      endfunction

      // Clamp a register value to the slots it really opens: 0 acts as 1
      function int unsigned usable_for(int unsigned value);
         if (value == 0) return 1;
         if (value > POOL_DEPTH) return POOL_DEPTH;
         return value;
      endfunction

      function int unsigned usable_slots();
         return usable_for(capacity_reg);
      endfunction

      // Advance a ring index, wrapping anything at or past the capacity
      function int unsigned next_index(int unsigned idx, int unsigned cap);
         return (idx + 1 >= cap) ? 0 : idx + 1;
      endfunction

      function void set_capacity(logic [CAP_BITS-1:0] value);
         capacity_reg = value;
      endfunction

      function int unsigned pending();
         return expected_answers.size();
      endfunction

      // Apply one command to the shadow ring and return the answer it gives
      function rsp_payload_type predict_answer(req_payload_type cmd_item);
         rsp_payload_type answer;
         int unsigned cap;
         int unsigned idx;
         logic [ERASE_BITS-1:0] low_erase;
         cap = usable_slots();
         answer = '0;
         case (cmd_item.command)
            CMD_PUSH: begin
               // full also when the capacity dropped below the held count
               if (held < cap) begin
                  idx = tail_idx % POOL_DEPTH;
                  slot_block[idx] = cmd_item.block_number;
                  slot_erase[idx] = cmd_item.block_erase_count;
                  tail_idx = next_index(idx, cap);
                  held++;
                  answer.ok = 1'b1;
               end
            end
            CMD_POP: begin
               if (held != 0) begin
                  idx = head_idx % POOL_DEPTH;
                  answer.result_block = slot_block[idx];
                  head_idx = next_index(idx, cap);
                  held--;
                  answer.ok = 1'b1;
               end
            end
            CMD_FIND: begin
               // walk from head; strict compare keeps the earliest on a tie
               if (held != 0) begin
                  idx = head_idx % POOL_DEPTH;
                  answer.result_block = slot_block[idx];
                  low_erase = slot_erase[idx];
                  for (int unsigned n = 0; n < held; n++) begin
                     if (slot_erase[idx] < low_erase) begin
                        answer.result_block = slot_block[idx];
                        low_erase = slot_erase[idx];
                     end
                     idx = next_index(idx, cap);
                  end
                  answer.ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         answer.occupancy = cnt_type'(held);
         return answer;
      endfunction

      // Record an accepted command and queue the answer it must produce
      function void note_command(req_payload_type cmd_item);
         rsp_payload_type answer;
         answer = predict_answer(cmd_item);
         by_command[cmd_item.command]++;
         if (!answer.ok) refused++;
         if (held > peak_held) peak_held = held;
         expected_answers.push_back(answer);
      endfunction

      // Compare one delivered answer with the oldest queued one
      function void check_answer(rsp_payload_type got);
         rsp_payload_type want;
         answers_checked++;
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("answer with nothing outstanding: ok=%0b block=%h occupancy=%0d",
                        got.ok, got.result_block, got.occupancy);
            end
            return;
         end
         want = expected_answers.pop_front();
         if (got.ok !== want.ok || got.result_block !== want.result_block ||
             got.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("answer %0d: expected ok=%0b block=%h occupancy=%0d,",
                        answers_checked, want.ok, want.result_block, want.occupancy);
               $display("   got ok=%0b block=%h occupancy=%0d",
                        got.ok, got.result_block, got.occupancy);
            end
         end
      endfunction
   endclass

endpackage

FILE: tb/sv/free_block_fifo_min_wear_tb.sv
// Top-level testbench: drives pool commands and capacity writes, checks every answer.
module free_block_fifo_min_wear_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbf_pkg::*;
   import fbf_tb_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1370;
   localparam int unsigned SETTLE_CYCLES = 40;

   logic clock = 1'b0;
   logic reset;
   bit steady_run;
   int unsigned items_sent = 0;
   int unsigned settings_written = 0;
   pool_tracker pool_model;

   fbf_req_if req_if ();
   fbf_rsp_if rsp_if ();
   fbf_csr_if csr_if ();

   free_block_fifo_min_wear u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // 100 MHz clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Check answers as they leave; stall the answer side at random
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         pool_model.check_answer(rsp_if.data);
      end
      rsp_if.ready <= steady_run || ($urandom_range(99) >= 15);
   end

   function automatic req_payload_type make_cmd(logic [CMD_BITS-1:0] code,
                                                logic [BLOCK_BITS-1:0] blk,
                                                logic [ERASE_BITS-1:0] wear);
      req_payload_type cmd_item;
      cmd_item.command = code;
      cmd_item.block_number = blk;
      cmd_item.block_erase_count = wear;
      return cmd_item;
   endfunction

   // Draw a command; erase counts often come from a narrow range to force ties
   function automatic req_payload_type random_command(int unsigned push_pct,
                                                      int unsigned pop_pct);
      req_payload_type cmd_item;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3) cmd_item.command = CMD_UNUSED;
      else if (roll < 3 + push_pct) cmd_item.command = CMD_PUSH;
      else if (roll < 3 + push_pct + pop_pct) cmd_item.command = CMD_POP;
      else cmd_item.command = CMD_FIND;
      cmd_item.block_number = ($urandom_range(7) == 0) ?
                              {BLOCK_BITS{$urandom_range(1) == 1}} : BLOCK_BITS'($urandom);
      case ($urandom_range(3))
         0: cmd_item.block_erase_count = ERASE_BITS'($urandom_range(7));
         1: cmd_item.block_erase_count = {ERASE_BITS{$urandom_range(1) == 1}};
         default: cmd_item.block_erase_count = ERASE_BITS'($urandom);
      endcase
      return cmd_item;
   endfunction

   // Offer one command, idling first at random, and hold it until taken
   task automatic send_command(input req_payload_type cmd_item);
      while (!steady_run && $urandom_range(99) < 15) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= cmd_item;
      do @(posedge clock); while (!req_if.ready);
      pool_model.note_command(cmd_item);
      items_sent++;
   endtask

   // Drop valid and hold until every queued answer has come back
   task automatic wait_for_answers();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pool_model.pending() != 0);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      pool_model.set_capacity(value);
      settings_written++;
   endtask

   // Change capacity on an idle block; empty the pool first when it grows, so
   // that no slot is read before it was written
   task automatic change_capacity(input logic [CAP_BITS-1:0] value);
      wait_for_answers();
      if (pool_model.usable_for(value) > pool_model.usable_slots()) begin
         while (pool_model.held != 0) begin
            send_command(make_cmd(CMD_POP, BLOCK_BITS'($urandom), ERASE_BITS'($urandom)));
         end
         wait_for_answers();
      end
      write_capacity(value);
   endtask

   // Give up on a hung run
   initial begin
      #100_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned directed_items;
      int unsigned phase;
      int unsigned phase_len;
      int unsigned push_pct;
      int unsigned pop_pct;
      logic [CAP_BITS-1:0] cap_value;

      pool_model = new();
      reset <= 1'b1;
      steady_run <= 1'b0;
      req_if.valid <= 1'b0;
      req_if.data <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty pool: reads are refused, the unused code does nothing
      send_command(make_cmd(CMD_POP, 16'hFFFF, 24'hFFFFFF));
      send_command(make_cmd(CMD_FIND, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_UNUSED, 16'hFFFF, 24'hFFFFFF));
      // Field extremes and a tie on the lowest wear
      send_command(make_cmd(CMD_PUSH, 16'hFFFF, 24'hFFFFFF));
      send_command(make_cmd(CMD_PUSH, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_PUSH, 16'h1234, 24'h000000));
      send_command(make_cmd(CMD_PUSH, 16'hA5A5, 24'h800000));
      send_command(make_cmd(CMD_FIND, 16'hFFFF, 24'hFFFFFF));
      send_command(make_cmd(CMD_UNUSED, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_FIND, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_FIND, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      // Capacity 0 acts as one slot; head and tail sit past it and wrap
      change_capacity(11'd0);
      send_command(make_cmd(CMD_PUSH, 16'h0F0F, 24'h00F00F));
      send_command(make_cmd(CMD_PUSH, 16'hF0F0, 24'hFF0FF0));
      send_command(make_cmd(CMD_FIND, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      // Out-of-range capacity acts as the full depth
      change_capacity(11'd2047);
      send_command(make_cmd(CMD_PUSH, 16'h0101, 24'h000005));
      send_command(make_cmd(CMD_PUSH, 16'h0202, 24'h000002));
      send_command(make_cmd(CMD_PUSH, 16'h0303, 24'h000002));
      // Capacity below the held count: pushes refused, reads wrap early
      change_capacity(11'd2);
      send_command(make_cmd(CMD_PUSH, 16'h0404, 24'h000001));
      send_command(make_cmd(CMD_FIND, 16'h0000, 24'h000000));
      send_command(make_cmd(CMD_POP, 16'h0000, 24'h000000));
      directed_items = items_sent;

      // Random phases, each at its own capacity and push/pop balance
      phase = 0;
      while (items_sent - directed_items < RANDOM_ITEMS) begin
         case (phase)
            0: cap_value = 11'd1;
            1: cap_value = 11'd1024;
            2: cap_value = 11'd1023;
            3: cap_value = 11'd2047;
            4: cap_value = 11'd0;
            default: begin
               if ($urandom_range(9) == 0) cap_value = CAP_BITS'($urandom_range(17, 2047));
               else cap_value = CAP_BITS'($urandom_range(1, 16));
            end
         endcase
         change_capacity(cap_value);
         steady_run <= (phase == 5);
         case ($urandom_range(2))
            0: begin
               push_pct = 60;
               pop_pct = 20;
            end
            1: begin
               push_pct = 25;
               pop_pct = 55;
            end
            default: begin
               push_pct = 40;
               pop_pct = 35;
            end
         endcase
         phase_len = $urandom_range(40, 100);
         for (int unsigned n = 0; n < phase_len; n++) begin
            send_command(random_command(push_pct, pop_pct));
         end
         phase++;
      end

      // Drain, then watch a while for stray answers
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d push, %0d pop, %0d find-min, %0d unused code,",
               items_sent, pool_model.by_command[CMD_PUSH], pool_model.by_command[CMD_POP],
               pool_model.by_command[CMD_FIND], pool_model.by_command[CMD_UNUSED]);
      $display("%0d refused; capacity written %0d times over %0d phases, peak occupancy %0d.",
               pool_model.refused, settings_written, phase, pool_model.peak_held);
      if (pool_model.mismatches == 0 && pool_model.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", pool_model.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
